// ----- design/wed_pkg.sv -----
`default_nettype none

package wed_pkg;

    localparam int CHAR_W    = 8;
    localparam int REQ_W     = 2;
    localparam int COST_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int DIST_W    = 11;
    localparam int DIST_MAX  = 2047;

    localparam logic [COST_W-1:0] SUB_COST_RST = 3'd2;
    localparam logic [COST_W-1:0] INS_COST_RST = 3'd1;
    localparam logic [COST_W-1:0] DEL_COST_RST = 3'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SUB = 2'd0,
        CFG_INS = 2'd1,
        CFG_DEL = 2'd2
    } t_cfg_idx;

    typedef enum logic [REQ_W-1:0] {
        REQ_FIRST   = 2'd0,
        REQ_SECOND  = 2'd1,
        REQ_COMPUTE = 2'd2
    } t_req;

    // control travelling along the cell row
    typedef struct packed {
        logic vld;
        logic last;
        logic res_vld;
    } t_link_ctl;

endpackage

`default_nettype wire

// ----- design/wed_in_if.sv -----
`default_nettype none

interface wed_in_if;
    logic                          valid;
    logic                          ready;
    logic [wed_pkg::REQ_W-1:0]     req_type;
    logic [wed_pkg::CHAR_W-1:0]    char_code;

    modport source (output valid, output req_type, output char_code, input ready);
    modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

`default_nettype wire

// ----- design/wed_out_if.sv -----
`default_nettype none

interface wed_out_if;
    logic                          valid;
    logic                          ready;
    logic [wed_pkg::DIST_W-1:0]    distance;
    logic                          length_overflow;

    modport source (output valid, output distance, output length_overflow, input ready);
    modport sink   (input valid, input distance, input length_overflow, output ready);
endinterface

`default_nettype wire

// ----- design/wed_cell.sv -----
`default_nettype none

module wed_cell #(
    parameter int IDX = 0,
    parameter int LW  = 8,
    parameter int VW  = 11
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_init,
    input  wire logic                           i_wr_en,
    input  wire logic [LW-1:0]                  i_wr_pos,
    input  wire logic [wed_pkg::CHAR_W-1:0]     i_wr_char,
    input  wire logic [wed_pkg::COST_W-1:0]     i_sub,
    input  wire logic [wed_pkg::COST_W-1:0]     i_ins,
    input  wire logic [wed_pkg::COST_W-1:0]     i_del,
    input  wire logic [LW-1:0]                  i_n,
    input  wire wed_pkg::t_link_ctl             i_ctl,
    input  wire logic [wed_pkg::CHAR_W-1:0]     i_ch,
    input  wire logic [VW-1:0]                  i_val,
    input  wire logic [VW-1:0]                  i_res,
    output wed_pkg::t_link_ctl                  o_ctl,
    output logic [wed_pkg::CHAR_W-1:0]          o_ch,
    output logic [VW-1:0]                       o_val,
    output logic [VW-1:0]                       o_res
);

    wed_pkg::t_link_ctl               r_ctl;
    logic [wed_pkg::CHAR_W-1:0]       r_b;
    logic [wed_pkg::CHAR_W-1:0]       r_ch;
    logic [VW-1:0]                    r_val;
    logic [VW-1:0]                    r_diag;
    logic [VW-1:0]                    r_res;
    logic [VW:0]                      w_s_sub;
    logic [VW:0]                      w_s_ins;
    logic [VW:0]                      w_s_del;
    logic [VW:0]                      w_m;
    logic [VW-1:0]                    w_new;
    logic                             w_is_n;

    assign w_is_n  = (i_n == LW'(IDX + 1));
    assign w_s_sub = {1'b0, r_diag}
                   + ((i_ch != r_b) ? (VW + 1)'(i_sub) : '0);
    assign w_s_ins = {1'b0, i_val} + (VW + 1)'(i_ins);
    assign w_s_del = {1'b0, r_val} + (VW + 1)'(i_del);

    always_comb begin
        w_m = (w_s_ins <= w_s_del) ? w_s_ins : w_s_del;
        if (w_s_sub <= w_m) begin
            w_m = w_s_sub;
        end
        w_new = w_m[VW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_init) begin
            r_ctl <= '0;
        end else begin
            r_ctl.vld  <= i_ctl.vld;
            r_ctl.last <= i_ctl.last;
            if (i_ctl.vld && i_ctl.last && w_is_n) begin
                r_ctl.res_vld <= 1'b1;
            end else begin
                r_ctl.res_vld <= i_ctl.res_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && (i_wr_pos == LW'(IDX))) begin
            r_b <= i_wr_char;
        end
        r_ch <= i_ch;
        if (i_init) begin
            r_val  <= VW'(IDX + 1) * VW'(i_ins);
            r_diag <= VW'(IDX) * VW'(i_ins);
        end else if (i_ctl.vld) begin
            r_val  <= w_new;
            r_diag <= i_val;
        end
        if (i_ctl.vld && i_ctl.last && w_is_n) begin
            r_res <= w_new;
        end else begin
            r_res <= i_res;
        end
    end

    assign o_ctl = r_ctl;
    assign o_ch  = r_ch;
    assign o_val = r_val;
    assign o_res = r_res;

endmodule

`default_nettype wire

// ----- design/weighted_edit_distance.sv -----
// Weighted edit distance between two byte words of up to MAX_LEN characters.
// Append requests (first or second word) are taken one per cycle while idle.
// A compute request returns the cheapest substitution/insertion/deletion cost
// and then empties both words; appends to a full word are dropped and flagged.
// With an empty word the result is the other word's length times the
// insertion or deletion cost; otherwise it is set by the wavefront of the
// first word streaming through the row of MAX_LEN cells (one per character
// of the second word) and the result passing down to the end of the row.
// Costs are to be written through the cfg port only while the block is idle;
// the block itself does not enforce this.
`default_nettype none

module weighted_edit_distance #(
    parameter int MAX_LEN = 128
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [wed_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [wed_pkg::COST_W-1:0]        i_cfg_data,
    wed_in_if.sink                                 i_req,
    wed_out_if.source                              o_res
);

    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int VW = $clog2(14 * MAX_LEN + 1);
    localparam int CW = (VW > wed_pkg::DIST_W) ? VW : wed_pkg::DIST_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_INIT = 5'b00010,
        S_RUN  = 5'b00100,
        S_WAIT = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                            r_state;
    t_state                            n_state;
    logic [wed_pkg::COST_W-1:0]        r_sub;
    logic [wed_pkg::COST_W-1:0]        r_ins;
    logic [wed_pkg::COST_W-1:0]        r_del;
    logic [LW-1:0]                     r_len_a;
    logic [LW-1:0]                     r_len_b;
    logic                              r_ovf;
    logic [IW-1:0]                     r_rd;
    logic                              r_src_vld;
    logic                              r_src_last;
    logic [wed_pkg::CHAR_W-1:0]        r_rd_data;
    logic [VW-1:0]                     r_dcol;
    logic [VW-1:0]                     r_dist;
    logic                              r_out_vld;
    logic [wed_pkg::DIST_W-1:0]        r_out_dist;
    logic                              r_out_ovf;
    logic [wed_pkg::CHAR_W-1:0]        r_mem_a [MAX_LEN];

    logic                              w_acc;
    wed_pkg::t_req                     w_req;
    logic                              w_wr_a;
    logic                              w_wr_b;
    logic                              w_full_hit;
    logic                              w_rd_last;
    logic                              w_load_out;
    logic [wed_pkg::DIST_W-1:0]        w_dist_sat;

    wed_pkg::t_link_ctl                w_ctl [MAX_LEN + 1];
    logic [wed_pkg::CHAR_W-1:0]        w_ch  [MAX_LEN + 1];
    logic [VW-1:0]                     w_val [MAX_LEN + 1];
    logic [VW-1:0]                     w_res [MAX_LEN + 1];

    assign i_req.ready = (r_state == S_IDLE);
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_req       = wed_pkg::t_req'(i_req.req_type);

    always_comb begin
        w_wr_a     = 1'b0;
        w_wr_b     = 1'b0;
        w_full_hit = 1'b0;
        if (w_acc) begin
            unique case (w_req)
                wed_pkg::REQ_FIRST: begin
                    w_wr_a     = (r_len_a < LW'(MAX_LEN));
                    w_full_hit = !w_wr_a;
                end
                wed_pkg::REQ_SECOND: begin
                    w_wr_b     = (r_len_b < LW'(MAX_LEN));
                    w_full_hit = !w_wr_b;
                end
                default: begin
                end
            endcase
        end
    end

    assign w_rd_last  = (LW'(r_rd) == (r_len_a - LW'(1)));
    assign w_load_out = (r_state == S_DONE) && (!r_out_vld || o_res.ready);

    always_comb begin
        if (CW'(r_dist) > CW'(wed_pkg::DIST_MAX)) begin
            w_dist_sat = wed_pkg::DIST_W'(wed_pkg::DIST_MAX);
        end else begin
            w_dist_sat = wed_pkg::DIST_W'(r_dist);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc && (w_req == wed_pkg::REQ_COMPUTE)) begin
                    if ((r_len_a == '0) || (r_len_b == '0)) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: n_state = S_RUN;
            S_RUN: begin
                if (w_rd_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_ctl[MAX_LEN].res_vld) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sub      <= wed_pkg::SUB_COST_RST;
            r_ins      <= wed_pkg::INS_COST_RST;
            r_del      <= wed_pkg::DEL_COST_RST;
            r_len_a    <= '0;
            r_len_b    <= '0;
            r_ovf      <= 1'b0;
            r_src_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (wed_pkg::t_cfg_idx'(i_cfg_idx))
                    wed_pkg::CFG_SUB: r_sub <= i_cfg_data;
                    wed_pkg::CFG_INS: r_ins <= i_cfg_data;
                    wed_pkg::CFG_DEL: r_del <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_wr_a) begin
                r_len_a <= r_len_a + LW'(1);
            end
            if (w_wr_b) begin
                r_len_b <= r_len_b + LW'(1);
            end
            if (w_full_hit) begin
                r_ovf <= 1'b1;
            end
            if (w_load_out) begin
                r_len_a <= '0;
                r_len_b <= '0;
                r_ovf   <= 1'b0;
            end
            r_src_vld <= (r_state == S_RUN);
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // first word store and wavefront source
    always_ff @(posedge i_clk) begin
        if (w_wr_a) begin
            r_mem_a[r_len_a[IW-1:0]] <= i_req.char_code;
        end
        r_rd_data  <= r_mem_a[r_rd];
        r_src_last <= w_rd_last;
        if (r_state == S_INIT) begin
            r_rd   <= '0;
            r_dcol <= '0;
        end else if (r_state == S_RUN) begin
            r_rd   <= r_rd + IW'(1);
            r_dcol <= r_dcol + VW'(r_del);
        end
        if ((r_state == S_IDLE) && w_acc) begin
            if (r_len_a == '0) begin
                r_dist <= VW'(r_len_b) * VW'(r_ins);
            end else begin
                r_dist <= VW'(r_len_a) * VW'(r_del);
            end
        end else if ((r_state == S_WAIT) && w_ctl[MAX_LEN].res_vld) begin
            r_dist <= w_res[MAX_LEN];
        end
        if (w_load_out) begin
            r_out_dist <= w_dist_sat;
            r_out_ovf  <= r_ovf;
        end
    end

    assign w_ctl[0] = '{vld: r_src_vld, last: r_src_last, res_vld: 1'b0};
    assign w_ch[0]  = r_rd_data;
    assign w_val[0] = r_dcol;
    assign w_res[0] = '0;

    for (genvar k = 0; k < MAX_LEN; k++) begin : g_cell
        wed_cell #(
            .IDX (k),
            .LW  (LW),
            .VW  (VW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_init    (r_state == S_INIT),
            .i_wr_en   (w_wr_b),
            .i_wr_pos  (r_len_b),
            .i_wr_char (i_req.char_code),
            .i_sub     (r_sub),
            .i_ins     (r_ins),
            .i_del     (r_del),
            .i_n       (r_len_b),
            .i_ctl     (w_ctl[k]),
            .i_ch      (w_ch[k]),
            .i_val     (w_val[k]),
            .i_res     (w_res[k]),
            .o_ctl     (w_ctl[k + 1]),
            .o_ch      (w_ch[k + 1]),
            .o_val     (w_val[k + 1]),
            .o_res     (w_res[k + 1])
        );
    end

    assign o_res.valid           = r_out_vld;
    assign o_res.distance        = r_out_dist;
    assign o_res.length_overflow = r_out_ovf;

endmodule

`default_nettype wire

// ----- design/wed_checker.sv -----
`default_nettype none

module wed_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           i_in_ready,
    input wire logic [wed_pkg::REQ_W-1:0]      i_in_req_type,
    input wire logic                           i_out_valid,
    input wire logic                           i_out_ready,
    input wire logic [wed_pkg::DIST_W-1:0]     i_out_distance
);

    logic w_acc_compute;
    logic w_acc_append;

    assign w_acc_compute = i_in_valid && i_in_ready
                        && (i_in_req_type == wed_pkg::REQ_COMPUTE);
    assign w_acc_append  = i_in_valid && i_in_ready
                        && ((i_in_req_type == wed_pkg::REQ_FIRST)
                         || (i_in_req_type == wed_pkg::REQ_SECOND));

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_distance))
        else $error("result changed while stalled");

    // busy after a compute request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_compute |=> !i_in_ready)
        else $error("request taken during compute");

    // appends never stall the input
    a_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc_append |=> i_in_ready)
        else $error("input stalled after append");

    // a new result only appears at the end of a compute
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("result without compute");

endmodule

bind weighted_edit_distance wed_checker u_wed_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_req.valid),
    .i_in_ready     (i_req.ready),
    .i_in_req_type  (i_req.req_type),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_distance (o_res.distance)
);

`default_nettype wire
